/* hw/rtl/pims_pkg.sv */
// Package for the per-id message statistics block: widths, codes and the
// command record passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pims_pkg;

  localparam int unsigned MaxIdsDefault = 64;
  localparam int unsigned FifoDepth     = 4;

  localparam int unsigned OpW      = 2;
  localparam int unsigned MsgIdW   = 16;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned AccW     = 33;
  localparam int unsigned LimW     = 7;
  localparam int unsigned IdW      = 6;
  localparam int unsigned CountW   = 32;
  localparam int unsigned BytesW   = 64;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [LimW-1:0] IdLimitReset = 7'd64;

  typedef enum logic [OpW-1:0] {
    OP_COUNT = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ID_LIMIT      = 1'b0,
    CFG_DUMP_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_COUNT = 1'b0,
    CMD_DUMP  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [IdW-1:0]   id;
    logic [SizeW-1:0] size;
  } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/pims_front.sv */
// Front end: holds the configuration registers and the time accumulator,
// classifies each accepted item and queues commands. Depends on pims_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pims_front
  import pims_pkg::*;
#(
  parameter int unsigned MAX_IDS = MaxIdsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  input  wire logic [OpW-1:0]      opcode_i,
  input  wire logic [MsgIdW-1:0]   msg_id_i,
  input  wire logic [SizeW-1:0]    msg_bytes_i,
  input  wire logic [TimeW-1:0]    elapsed_i,
  output logic                     push_o,
  output cmd_t                     push_cmd_o,
  output logic [LimW-1:0]          lim_o
);

  logic [LimW-1:0]  id_limit_q;
  logic [TimeW-1:0] dump_interval_q;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [AccW-1:0]  acc_sum;
  logic [AccW:0]    acc_diff;

  assign lim_o = (id_limit_q < LimW'(MAX_IDS)) ? id_limit_q : LimW'(MAX_IDS);

  always_comb begin
    acc_sum    = acc_q + {1'b0, elapsed_i};
    acc_diff   = {1'b0, acc_sum} - {2'b00, dump_interval_q};
    acc_d      = acc_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: CMD_COUNT, id: msg_id_i[IdW-1:0], size: msg_bytes_i};
    if (in_valid_i) begin
      case (op_e'(opcode_i))
        OP_COUNT: begin
          if (msg_id_i < {{(MsgIdW-LimW){1'b0}}, lim_o}) begin
            push_o = 1'b1;
          end
        end
        OP_TICK: begin
          if (dump_interval_q != '0) begin
            if (!acc_diff[AccW]) begin
              acc_d           = acc_diff[AccW-1:0];
              push_o          = 1'b1;
              push_cmd_o.kind = CMD_DUMP;
            end else begin
              acc_d = acc_sum;
            end
          end
        end
        OP_FLUSH: begin
          push_o          = 1'b1;
          push_cmd_o.kind = CMD_DUMP;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_limit_q      <= IdLimitReset;
      dump_interval_q <= '0;
      acc_q           <= '0;
    end else begin
      acc_q <= acc_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ID_LIMIT:      id_limit_q      <= cfg_wdata_i[LimW-1:0];
          CFG_DUMP_INTERVAL: dump_interval_q <= cfg_wdata_i[TimeW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pims_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on pims_pkg for the command record.
`timescale 1ns / 1ps
`default_nettype none
module pims_cmd_fifo
  import pims_pkg::*;
#(
  parameter int unsigned DEPTH = FifoDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      head_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;
  logic            do_push, do_pop;

  assign valid_o = (fill_q != '0);
  assign full_o  = (fill_q == CntW'(DEPTH));
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pims_back.sv */
// Back end: the count and byte table, count updates and the dump walk that
// emits and clears nonzero entries. Depends on pims_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pims_back
  import pims_pkg::*;
#(
  parameter int unsigned MAX_IDS = MaxIdsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire cmd_t              cmd_i,
  output logic                   pop_o,
  input  wire logic [LimW-1:0]   lim_i,
  output logic                   entry_valid_o,
  output logic [IdW-1:0]         entry_id_o,
  output logic [CountW-1:0]      entry_count_o,
  output logic [BytesW-1:0]      entry_bytes_o,
  output logic                   last_o
);

  localparam int unsigned IdxW  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned WordW = CountW + BytesW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DUMP
  } state_e;

  state_e             state_q;
  logic [WordW-1:0]   mem_q [MAX_IDS];
  logic [WordW-1:0]   rd_q;
  logic [MAX_IDS-1:0] valid_q;
  logic [IdxW-1:0]    rd_addr;
  logic               mem_we;
  logic [WordW-1:0]   mem_wdata;

  logic [IdxW-1:0]    upd_id_q;
  logic [SizeW-1:0]   upd_size_q;
  logic [LimW-1:0]    scan_q;
  logic               chk_vld_q;
  logic [IdxW-1:0]    chk_id_q;
  logic               pend_vld_q;
  logic [IdW-1:0]     pend_id_q;
  logic [CountW-1:0]  pend_count_q;
  logic [BytesW-1:0]  pend_bytes_q;
  logic               out_vld_q, out_last_q;
  logic [IdW-1:0]     out_id_q;
  logic [CountW-1:0]  out_count_q;
  logic [BytesW-1:0]  out_bytes_q;

  logic [CountW-1:0]  cur_count;
  logic [BytesW-1:0]  cur_bytes;
  logic [IdxW-1:0]    cur_id;
  logic               scan_more, hit;

  assign pop_o     = (state_q == S_IDLE) && cmd_valid_i;
  assign rd_addr   = (state_q == S_DUMP) ? scan_q[IdxW-1:0] : cmd_i.id[IdxW-1:0];
  assign cur_id    = (state_q == S_DUMP) ? chk_id_q : upd_id_q;
  assign cur_count = valid_q[cur_id] ? rd_q[WordW-1:BytesW] : '0;
  assign cur_bytes = valid_q[cur_id] ? rd_q[BytesW-1:0] : '0;
  assign scan_more = (scan_q < lim_i);
  assign hit       = chk_vld_q && (cur_count != '0);
  assign mem_we    = (state_q == S_UPDATE);
  assign mem_wdata = {cur_count + 1'b1, cur_bytes + {{(BytesW-SizeW){1'b0}}, upd_size_q}};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[upd_id_q] <= mem_wdata;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      valid_q      <= '0;
      upd_id_q     <= '0;
      upd_size_q   <= '0;
      scan_q       <= '0;
      chk_vld_q    <= 1'b0;
      chk_id_q     <= '0;
      pend_vld_q   <= 1'b0;
      pend_id_q    <= '0;
      pend_count_q <= '0;
      pend_bytes_q <= '0;
      out_vld_q    <= 1'b0;
      out_last_q   <= 1'b0;
      out_id_q     <= '0;
      out_count_q  <= '0;
      out_bytes_q  <= '0;
    end else begin
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.kind == CMD_COUNT) begin
              upd_id_q   <= cmd_i.id[IdxW-1:0];
              upd_size_q <= cmd_i.size;
              state_q    <= S_UPDATE;
            end else begin
              scan_q     <= '0;
              chk_vld_q  <= 1'b0;
              pend_vld_q <= 1'b0;
              state_q    <= S_DUMP;
            end
          end
        end
        S_UPDATE: begin
          valid_q[upd_id_q] <= 1'b1;
          state_q           <= S_IDLE;
        end
        S_DUMP: begin
          chk_vld_q <= scan_more;
          if (scan_more) begin
            scan_q   <= scan_q + 1'b1;
            chk_id_q <= scan_q[IdxW-1:0];
          end
          if (hit) begin
            valid_q[chk_id_q] <= 1'b0;
            if (pend_vld_q) begin
              out_vld_q   <= 1'b1;
              out_id_q    <= pend_id_q;
              out_count_q <= pend_count_q;
              out_bytes_q <= pend_bytes_q;
            end
            pend_vld_q   <= 1'b1;
            pend_id_q    <= IdW'(chk_id_q);
            pend_count_q <= cur_count;
            pend_bytes_q <= cur_bytes;
          end else if (!chk_vld_q && !scan_more) begin
            if (pend_vld_q) begin
              out_vld_q   <= 1'b1;
              out_last_q  <= 1'b1;
              out_id_q    <= pend_id_q;
              out_count_q <= pend_count_q;
              out_bytes_q <= pend_bytes_q;
            end
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign entry_valid_o = out_vld_q;
  assign last_o        = out_last_q;
  assign entry_id_o    = out_id_q;
  assign entry_count_o = out_count_q;
  assign entry_bytes_o = out_bytes_q;

endmodule
`default_nettype wire

/* hw/rtl/per_id_message_statistics.sv */
// Top level of the per-id message statistics block: front end, command
// queue and back end. Depends on pims_pkg, pims_front, pims_cmd_fifo, pims_back.
//
//   channel   handshake              payload
//   input     start, busy            opcode_i, msg_id_i, msg_bytes_i, elapsed_i
//   result    entry_valid_o          entry_id_o, entry_count_o, entry_bytes_o, last_o
//   config    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// An item is taken whenever busy is low; busy rises only when the four-entry
// command queue is full. A count item occupies the table for a read, then a write
// back. A dump walks the table entries below the active id limit, emitting one
// item per cycle at most. Results appear for one cycle and cannot be held off.
// Reset clears the table through per-entry valid bits, so the block needs no
// clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module per_id_message_statistics
  import pims_pkg::*;
#(
  parameter int unsigned MAX_IDS = MaxIdsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OpW-1:0]      opcode_i,
  input  wire logic [MsgIdW-1:0]   msg_id_i,
  input  wire logic [SizeW-1:0]    msg_bytes_i,
  input  wire logic [TimeW-1:0]    elapsed_i,
  output logic                     entry_valid_o,
  output logic [IdW-1:0]           entry_id_o,
  output logic [CountW-1:0]        entry_count_o,
  output logic [BytesW-1:0]        entry_bytes_o,
  output logic                     last_o
);

  logic            in_valid;
  logic            push;
  cmd_t            push_cmd;
  logic [LimW-1:0] lim;
  logic            cmd_valid;
  cmd_t            head_cmd;
  logic            pop;
  logic            full;

  assign busy     = full;
  assign in_valid = start && !full;

  pims_front #(
    .MAX_IDS(MAX_IDS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid),
    .opcode_i   (opcode_i),
    .msg_id_i   (msg_id_i),
    .msg_bytes_i(msg_bytes_i),
    .elapsed_i  (elapsed_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .lim_o      (lim)
  );

  pims_cmd_fifo #(
    .DEPTH(FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .valid_o   (cmd_valid),
    .head_o    (head_cmd),
    .full_o    (full)
  );

  pims_back #(
    .MAX_IDS(MAX_IDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .lim_i        (lim),
    .entry_valid_o(entry_valid_o),
    .entry_id_o   (entry_id_o),
    .entry_count_o(entry_count_o),
    .entry_bytes_o(entry_bytes_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/pims_checker.sv */
// Port-level checks for the per-id message statistics block, bound to the
// top level. Depends on pims_pkg and per_id_message_statistics.
`timescale 1ns / 1ps
`default_nettype none
module pims_checker
  import pims_pkg::*;
#(
  parameter int unsigned MAX_IDS = MaxIdsDefault
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              entry_valid_o,
  input wire logic [IdW-1:0]    entry_id_o,
  input wire logic [CountW-1:0] entry_count_o,
  input wire logic              last_o
);

  // A dumped entry always carries a nonzero count.
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_o |-> (entry_count_o != '0))
    else $error("dumped entry with zero count");

  a_id_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_o |-> (int'(entry_id_o) < MAX_IDS))
    else $error("dumped id beyond table size");

  // Within one dump, back-to-back items come in strictly ascending id order.
  a_ascending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_valid_o && !last_o) |=> (!entry_valid_o || (entry_id_o > $past(entry_id_o))))
    else $error("dump items out of order");

endmodule

bind per_id_message_statistics pims_checker #(
  .MAX_IDS(MAX_IDS)
) u_pims_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .entry_valid_o(entry_valid_o),
  .entry_id_o   (entry_id_o),
  .entry_count_o(entry_count_o),
  .last_o       (last_o)
);
`default_nettype wire
